// ----- design/bpt_pkg.sv -----
// ----------------------------------------------------------------------------
// bpt_pkg: shared types and codes for the bidirectional pair table
// Opcodes, status codes, field widths and the item structs passed between
// the top level and the sequencer.
// ----------------------------------------------------------------------------
package bpt_pkg;

   localparam int OPCODE_W = 3;
   localparam int FIELD_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // tdata widths, rounded up to whole bytes
   localparam int REQ_BITS    = OPCODE_W + 2 * FIELD_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = STATUS_W + FIELD_W + COUNT_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [OPCODE_W-1:0] OP_ADD    = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_BY_X   = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_BY_Y   = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BADREM = 2'd3;

   typedef struct packed {
      logic [FIELD_W-1:0]  y_value;
      logic [FIELD_W-1:0]  x_value;
      logic [OPCODE_W-1:0] opcode;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  entry_count;
      logic [FIELD_W-1:0]  answer;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

// ----- design/bidirectional_pair_table.sv -----
// ----------------------------------------------------------------------------
// bidirectional_pair_table: table of (x, y) pairs searchable in both directions
// Stream-in operations, stream-out one result item per operation.
// ----------------------------------------------------------------------------
// The block keeps up to DEPTH pairs in insertion order in one RAM (x in the
// low half of a word, y in the high half) and executes one operation per
// request item: add, remove last (only when x matches the last stored x),
// lookup by x, lookup by y, clear. Every request item yields exactly one
// response item with a status, the partner value found by a lookup (zero
// otherwise) and the pair count after the operation. Operations run one at
// a time: add, clear, unused opcodes and misses on an empty table pass
// through the execute and finish states; remove also reads and compares
// the last entry; a lookup scans the table one entry per cycle through the
// single RAM read port and one shared comparator, stopping at the first
// match or after the last stored pair. A finished response sits in the
// output register while the next request is accepted; the sequencer only
// holds at the end of that next operation if the response is still not
// taken. No clearing pass is needed after reset: entries at or above the
// pair count are never read. KEY_WIDTH keys are compared and stored in
// their low bits (at most 32, the field width).
// ----------------------------------------------------------------------------
module bidirectional_pair_table #(
   parameter int DEPTH     = 16,
   parameter int KEY_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   // request item stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [2:0] opcode, [34:3] x_value, [66:35] y_value, [71:67] zero
   input  logic [bpt_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // response item stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [1:0] status, [33:2] answer, [38:34] entry_count, [39] zero
   output logic [bpt_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   // stored key width: inputs carry only FIELD_W bits
   localparam int KEY_W = (KEY_WIDTH < bpt_pkg::FIELD_W) ? KEY_WIDTH : bpt_pkg::FIELD_W;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   bpt_pkg::req_type   req_item;
   bpt_pkg::rsp_type   result;
   bpt_pkg::rsp_type   rsp_item_ff, rsp_item_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               req_fire;
   logic               idle;
   logic               done;
   logic               out_free;

   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [2*KEY_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [AW-1:0]      ram_rd_addr;
   logic [2*KEY_W-1:0] ram_rd_data;

   assign req_item   = req_tdata[bpt_pkg::REQ_BITS-1:0];
   assign req_tready = idle;
   assign req_fire   = req_tvalid && req_tready;

   // output register frees up in the same cycle it is taken
   assign out_free = !rsp_valid_ff || rsp_tready;

   bpt_ctrl #(
      .DEPTH (DEPTH),
      .KEY_W (KEY_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_fire),
      .req_item    (req_item),
      .idle        (idle),
      .out_free    (out_free),
      .done        (done),
      .result      (result),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   bpt_ram #(
      .WIDTH (2 * KEY_W),
      .DEPTH (DEPTH)
   ) u_pairs (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = bpt_pkg::RSP_TDATA_W'(rsp_item_ff);

`ifndef SYNTH
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      done |-> (!rsp_valid_ff || rsp_tready))
      else $error("response register overwritten before taken");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("second request accepted while an operation runs");

   a_done_only_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> !req_tready)
      else $error("response produced while sequencer idle");
`endif

endmodule

// ----- design/bpt_ram.sv -----
// ----------------------------------------------------------------------------
// bpt_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module bpt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/bpt_ctrl.sv -----
// ----------------------------------------------------------------------------
// bpt_ctrl: operation sequencer and shared key comparator
// Runs one operation at a time; lookups scan the RAM one entry per cycle.
// ----------------------------------------------------------------------------
module bpt_ctrl #(
   parameter int DEPTH = 16,
   parameter int KEY_W = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_fire,
   input  bpt_pkg::req_type                        req_item,
   output logic                                    idle,
   input  logic                                    out_free,
   output logic                                    done,
   output bpt_pkg::rsp_type                        result,
   output logic                                    ram_wr_en,
   output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ram_wr_addr,
   output logic [2*KEY_W-1:0]                      ram_wr_data,
   output logic                                    ram_rd_en,
   output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ram_rd_addr,
   input  logic [2*KEY_W-1:0]                      ram_rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_EXEC   = 4'b0010,
      S_SCAN   = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type                       state_ff, state_in;
   logic [bpt_pkg::OPCODE_W-1:0]    op_ff, op_in;
   logic [KEY_W-1:0]                x_ff, x_in;
   logic [KEY_W-1:0]                y_ff, y_in;
   logic [AW-1:0]                   idx_ff, idx_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic [bpt_pkg::STATUS_W-1:0]    status_ff, status_in;
   logic [bpt_pkg::FIELD_W-1:0]     answer_ff, answer_in;

   logic [KEY_W-1:0]                rd_x, rd_y;
   logic                            key_hit;
   logic [KEY_W-1:0]                partner;
   logic [CW-1:0]                   idx_plus;
   logic [CW-1:0]                   last_idx;

   assign rd_x     = ram_rd_data[KEY_W-1:0];
   assign rd_y     = ram_rd_data[2*KEY_W-1:KEY_W];
   // one comparator serves remove, lookup by x and lookup by y
   assign key_hit  = (op_ff == bpt_pkg::OP_BY_Y) ? (rd_y == y_ff) : (rd_x == x_ff);
   assign partner  = (op_ff == bpt_pkg::OP_BY_Y) ? rd_x : rd_y;
   assign idx_plus = CW'(idx_ff) + CW'(1);
   assign last_idx = count_ff - CW'(1);

   assign ram_wr_addr = AW'(count_ff);
   assign ram_wr_data = {y_ff, x_ff};

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      status_in   = status_ff;
      answer_in   = answer_ff;
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = AW'(idx_plus);
      done        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in     = req_item.opcode;
               x_in      = req_item.x_value[KEY_W-1:0];
               y_in      = req_item.y_value[KEY_W-1:0];
               status_in = bpt_pkg::ST_OK;
               answer_in = '0;
               idx_in    = '0;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_FINISH;
            case (op_ff)
               bpt_pkg::OP_ADD: begin
                  if (count_ff == CW'(DEPTH)) begin
                     status_in = bpt_pkg::ST_FULL;
                  end else begin
                     ram_wr_en = 1'b1;
                     count_in  = count_ff + CW'(1);
                  end
               end
               bpt_pkg::OP_REMOVE: begin
                  if (count_ff == '0) begin
                     status_in = bpt_pkg::ST_BADREM;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = AW'(last_idx);
                     idx_in      = AW'(last_idx);
                     state_in    = S_SCAN;
                  end
               end
               bpt_pkg::OP_BY_X, bpt_pkg::OP_BY_Y: begin
                  if (count_ff == '0) begin
                     status_in = bpt_pkg::ST_MISS;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = '0;
                     idx_in      = '0;
                     state_in    = S_SCAN;
                  end
               end
               bpt_pkg::OP_CLEAR: begin
                  count_in = '0;
               end
               default: begin
                  // unused opcodes: plain ok, table untouched
               end
            endcase
         end
         S_SCAN: begin
            // read data belongs to entry idx_ff
            if (key_hit) begin
               if (op_ff == bpt_pkg::OP_REMOVE) begin
                  count_in = count_ff - CW'(1);
               end else begin
                  answer_in = bpt_pkg::FIELD_W'(partner);
               end
               state_in = S_FINISH;
            end else if (op_ff == bpt_pkg::OP_REMOVE) begin
               status_in = bpt_pkg::ST_BADREM;
               state_in  = S_FINISH;
            end else if (idx_plus == count_ff) begin
               status_in = bpt_pkg::ST_MISS;
               state_in  = S_FINISH;
            end else begin
               ram_rd_en = 1'b1;
               idx_in    = AW'(idx_plus);
            end
         end
         S_FINISH: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      op_ff     <= op_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      answer_ff <= answer_in;
   end

   assign idle               = (state_ff == S_IDLE);
   assign result.status      = status_ff;
   assign result.answer      = answer_ff;
   assign result.entry_count = bpt_pkg::COUNT_W'(count_ff);

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("pair count above table depth");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (count_ff < CW'(DEPTH)))
      else $error("write into a full table");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (CW'(idx_ff) < count_ff))
      else $error("scan index beyond stored pairs");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_FINISH) && (status_ff == bpt_pkg::ST_FULL))
         |-> (count_ff == CW'(DEPTH)))
      else $error("full status with room left");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stream-level check of the bidirectional pair table
// Sends add, remove, lookup, clear and spare opcodes through the request
// stream, keeps its own copy of the pair table to predict each response
// item, and compares every response field by field under random bursts,
// gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
   import bpt_pkg::*;

   localparam int TABLE_DEPTH   = 16;
   localparam int RANDOM_ITEMS  = 1000;
   localparam int SEGMENT_ITEMS = 40;     // items per add-bias segment
   localparam int DRAIN_EVERY   = 250;    // sender waits for an empty scoreboard
   localparam int LONG_HOLD     = 120;    // receiver back-pressure stretch
   localparam int SETTLE_CYCLES = 40;     // quiet tail after the last response
   localparam int IDLE_LIMIT    = 2000;   // cycles with no handshake at all

   // opcodes the block ignores
   localparam logic [OPCODE_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_SPARE_LAST  = 3'd7;

   localparam logic [FIELD_W-1:0] KEY_ZERO = '0;
   localparam logic [FIELD_W-1:0] KEY_ONES = '1;

   typedef struct {
      req_type fields;
      bit      wait_drain;   // hold this item until all responses are back
   } pending_op_t;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   bidirectional_pair_table #(
      .DEPTH     (TABLE_DEPTH),
      .KEY_WIDTH (FIELD_W)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   pending_op_t pending_ops[$];
   rsp_type     expected_results[$];
   int unsigned results_seen = 0;
   int unsigned error_count  = 0;

   // ------------------------------------------------------------------------
   // Pair table predictor: insertion-ordered x/y arrays plus a count.
   // Only entries below pair_total are ever read.
   // ------------------------------------------------------------------------
   logic [FIELD_W-1:0] pair_x [TABLE_DEPTH];
   logic [FIELD_W-1:0] pair_y [TABLE_DEPTH];
   int unsigned        pair_total = 0;

   function automatic rsp_type apply_table_op(req_type op);
      rsp_type res;
      bit      hit;
      bit      match;
      res        = '0;
      res.status = ST_OK;
      hit        = 1'b0;
      case (op.opcode)
         OP_ADD: begin
            if (pair_total >= TABLE_DEPTH) begin
               res.status = ST_FULL;      // table left as is
            end else begin
               pair_x[pair_total] = op.x_value;
               pair_y[pair_total] = op.y_value;
               pair_total++;
            end
         end
         OP_REMOVE: begin
            // pops only when x names the newest pair
            if (pair_total == 0 || pair_x[pair_total-1] != op.x_value)
               res.status = ST_BADREM;
            else
               pair_total--;
         end
         OP_BY_X, OP_BY_Y: begin
            // oldest matching entry wins
            for (int idx = 0; idx < pair_total && !hit; idx++) begin
               match = (op.opcode == OP_BY_X) ? (pair_x[idx] == op.x_value)
                                               : (pair_y[idx] == op.y_value);
               if (match) begin
                  hit        = 1'b1;
                  res.answer = (op.opcode == OP_BY_X) ? pair_y[idx] : pair_x[idx];
               end
            end
            if (!hit)
               res.status = ST_MISS;
         end
         OP_CLEAR: begin
            pair_total = 0;
         end
         default: ;                       // spare opcodes: no effect
      endcase
      res.entry_count = COUNT_W'(pair_total);
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("mismatch on response %0d: %s expected %0h got %0h",
               results_seen, what, want, got);
      error_count++;
   endtask

   // ------------------------------------------------------------------------
   // Request driver: bursts of random length, random gaps between them.
   // A quarter of the bursts start without a gap.
   // ------------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      bit offer;
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = $urandom_range(16, 1);
         gap_left   = 0;
      end else begin
         offer = req_tvalid;
         if (req_tvalid && req_tready) begin
            // item taken: predict its response now, in accept order
            expected_results.push_back(apply_table_op(pending_ops[0].fields));
            void'(pending_ops.pop_front());
            offer = 1'b0;
            if (burst_left > 0)
               burst_left--;
            if (burst_left == 0) begin
               burst_left = ($urandom_range(7) == 0) ? $urandom_range(60, 20)
                                                     : $urandom_range(16, 1);
               gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
            end
         end
         if (!offer) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_ops.size() != 0 &&
                         !(pending_ops[0].wait_drain && expected_results.size() != 0)) begin
               offer = 1'b1;
               req_tdata <= {{(REQ_TDATA_W-REQ_BITS){1'b0}}, pending_ops[0].fields};
            end
         end
         req_tvalid <= offer;
      end
   end

   // ------------------------------------------------------------------------
   // Response receiver: stall rate changes in stretches (never, some, most),
   // plus long holds that back the block up into its request side.
   // ------------------------------------------------------------------------
   int          hold_left    = 0;
   int          stall_pct    = 0;
   int          mode_left    = 0;
   int unsigned next_hold_at = 250;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
         mode_left = 0;
      end else begin
         if (hold_left == 0 && results_seen >= next_hold_at) begin
            hold_left    = LONG_HOLD;
            next_hold_at = next_hold_at + 400;
         end
         if (mode_left == 0) begin
            mode_left = $urandom_range(64, 8);
            case ($urandom_range(2))
               0:       stall_pct = 0;
               1:       stall_pct = 30;
               default: stall_pct = 75;
            endcase
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor: oldest expectation first, field by field.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         got = rsp_type'(rsp_tdata[RSP_BITS-1:0]);
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected response, raw", 64'd0, 64'(rsp_tdata));
         end else begin
            want = expected_results.pop_front();
            if (got.status != want.status)
               report_mismatch("status", 64'(want.status), 64'(got.status));
            if (got.answer != want.answer)
               report_mismatch("answer", 64'(want.answer), 64'(got.answer));
            if (got.entry_count != want.entry_count)
               report_mismatch("entry_count", 64'(want.entry_count),
                               64'(got.entry_count));
         end
         if (rsp_tdata[RSP_TDATA_W-1:RSP_BITS] != '0)
            report_mismatch("pad bits", 64'd0,
                            64'(rsp_tdata[RSP_TDATA_W-1:RSP_BITS]));
      end
   end

   // Watchdog: a hung handshake ends the run.
   int unsigned idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   logic [FIELD_W-1:0] key_pool [8];

   task automatic queue_op(input logic [OPCODE_W-1:0] code,
                           input logic [FIELD_W-1:0] xv, input logic [FIELD_W-1:0] yv,
                           input bit drain);
      pending_op_t item;
      item.fields.opcode  = code;
      item.fields.x_value = xv;
      item.fields.y_value = yv;
      item.wait_drain     = drain;
      pending_ops.push_back(item);
   endtask

   // Small shared pool for x and y so duplicates and cross hits are common.
   function automatic logic [FIELD_W-1:0] pick_key();
      if ($urandom_range(9) < 6)
         return key_pool[$urandom_range(7)];
      return $urandom;
   endfunction

   initial begin
      logic [FIELD_W-1:0]  gen_x[$];   // keys the generator believes are stored
      logic [FIELD_W-1:0]  gen_y[$];
      logic [OPCODE_W-1:0] code;
      logic [FIELD_W-1:0]  xv;
      logic [FIELD_W-1:0]  yv;
      int                  add_pct;
      int                  draw;

      key_pool[0] = KEY_ZERO;
      key_pool[1] = KEY_ONES;
      for (int k = 2; k < 8; k++)
         key_pool[k] = $urandom;

      // --- directed: empty table, duplicates, first-match, remove rules ---
      queue_op(OP_BY_X,   KEY_ZERO, KEY_ZERO, 1'b0);   // miss on empty
      queue_op(OP_BY_Y,   KEY_ZERO, KEY_ONES, 1'b0);   // miss on empty
      queue_op(OP_REMOVE, KEY_ZERO, KEY_ZERO, 1'b0);   // remove on empty
      queue_op(OP_ADD,    KEY_ZERO, KEY_ONES, 1'b0);
      queue_op(OP_ADD,    KEY_ONES, KEY_ZERO, 1'b0);
      queue_op(OP_ADD,    KEY_ZERO, 32'd5,    1'b0);   // duplicate x
      queue_op(OP_ADD,    32'hA5A5_A5A5, 32'd5, 1'b0); // duplicate y
      queue_op(OP_BY_X,   KEY_ZERO, $urandom, 1'b0);   // oldest x=0 wins
      queue_op(OP_BY_Y,   $urandom, 32'd5,    1'b0);   // oldest y=5 wins
      queue_op(OP_BY_X,   KEY_ONES, $urandom, 1'b0);
      queue_op(OP_BY_Y,   $urandom, KEY_ONES, 1'b0);
      queue_op(OP_BY_Y,   $urandom, KEY_ZERO, 1'b0);
      queue_op(OP_BY_X,   32'h1234_5678, KEY_ZERO, 1'b0); // miss
      queue_op(OP_BY_Y,   KEY_ZERO, 32'h8765_4321, 1'b0); // miss
      queue_op(OP_REMOVE, KEY_ZERO, KEY_ZERO, 1'b0);   // x is not the newest
      queue_op(OP_REMOVE, 32'hA5A5_A5A5, $urandom, 1'b0);
      for (int s = OP_SPARE_FIRST; s <= OP_SPARE_LAST; s++)
         queue_op(OPCODE_W'(s), $urandom, $urandom, 1'b0);
      queue_op(OP_REMOVE, KEY_ZERO, KEY_ONES, 1'b0);
      queue_op(OP_CLEAR,  $urandom, $urandom, 1'b0);
      queue_op(OP_BY_X,   KEY_ONES, KEY_ONES, 1'b0);   // stale entry must not hit
      queue_op(OP_ADD,    $urandom, $urandom, 1'b0);
      queue_op(OP_CLEAR,  KEY_ONES, KEY_ONES, 1'b0);

      // --- random: each segment is randomly biased toward filling or mixed traffic ---
      add_pct = 70;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % SEGMENT_ITEMS == 0 && n != 0)
            add_pct = $urandom_range(1) ? 70 : 30;
         xv   = pick_key();
         yv   = pick_key();
         draw = $urandom_range(99);
         if (draw < add_pct) begin
            code = OP_ADD;
            if (gen_x.size() < TABLE_DEPTH) begin
               gen_x.push_back(xv);
               gen_y.push_back(yv);
            end
         end else begin
            draw = $urandom_range(99);
            if (draw < 35) begin
               code = OP_REMOVE;
               if (gen_x.size() != 0 && $urandom_range(3) != 0)
                  xv = gen_x[$];
               if (gen_x.size() != 0 && gen_x[$] == xv) begin
                  void'(gen_x.pop_back());
                  void'(gen_y.pop_back());
               end
            end else if (draw < 60) begin
               code = OP_BY_X;
               if (gen_x.size() != 0 && $urandom_range(9) < 7)
                  xv = gen_x[$urandom_range(gen_x.size() - 1)];
            end else if (draw < 85) begin
               code = OP_BY_Y;
               if (gen_y.size() != 0 && $urandom_range(9) < 7)
                  yv = gen_y[$urandom_range(gen_y.size() - 1)];
            end else if (draw < 92) begin
               code = OP_CLEAR;
               gen_x.delete();
               gen_y.delete();
            end else begin
               code = OP_SPARE_FIRST + OPCODE_W'($urandom_range(OP_SPARE_LAST - OP_SPARE_FIRST));
            end
         end
         queue_op(code, xv, yv, (n % DRAIN_EVERY) == 0);
      end

      // hold reset, then release it
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // all items sent, all responses back, then a quiet tail
      @(posedge clock);
      while (pending_ops.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
